// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ALL(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bmhq_pkg.sv =====
// ---------------------------------------------------------------------------
// bmhq_pkg
// Types, sizes and codes for the binary min-heap queue.
// ---------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int VAL_W    = 32;
    localparam int ENTRY_W  = 11;
    localparam int STAT_W   = 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } cmp_req_t;

endpackage

// ===== hw/rtl/bmhq_ram.sv =====
// ---------------------------------------------------------------------------
// bmhq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bmhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bmhq_cmp.sv =====
// ---------------------------------------------------------------------------
// bmhq_cmp
// Shared signed less-than unit used by both sift directions.
// ---------------------------------------------------------------------------
module bmhq_cmp import bmhq_pkg::*; (
    input  cmp_req_t req,
    output logic     lt
);

    assign lt = ($signed(req.a) < $signed(req.b));

endmodule

// ===== hw/rtl/bmhq_seq.sv =====
// ---------------------------------------------------------------------------
// bmhq_seq
// Sift sequencer: hole-based sift-up and sift-down, count and result beat.
// ---------------------------------------------------------------------------
module bmhq_seq import bmhq_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     op,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [VAL_W-1:0]  min_value,
    output logic [ENTRY_W-1:0]       entry_count,
    output mem_req_t                 mem_req,
    input  logic signed [VAL_W-1:0]  rd_data,
    output cmp_req_t                 cmp_req,
    input  logic                     cmp_lt
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UP   = 4'd1;
    localparam logic [3:0] S_UPC  = 4'd2;
    localparam logic [3:0] S_EX1  = 4'd3;
    localparam logic [3:0] S_EX2  = 4'd4;
    localparam logic [3:0] S_DN   = 4'd5;
    localparam logic [3:0] S_DNL  = 4'd6;
    localparam logic [3:0] S_DNR  = 4'd7;
    localparam logic [3:0] S_DNC  = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic [ADDR_W-1:0]       pidx_reg, pidx_next;
    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic signed [VAL_W-1:0] pv_reg, pv_next;
    logic signed [VAL_W-1:0] min_reg, min_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic signed [VAL_W-1:0] out_min_reg, out_min_next;
    logic [ENTRY_W-1:0]      out_count_reg, out_count_next;

    logic                    accept;
    logic                    out_take;
    logic                    load_out;
    logic [STAT_W-1:0]       ld_status;
    logic signed [VAL_W-1:0] ld_min;
    logic [CNT_W-1:0]        left;
    logic [CNT_W:0]          right_ext;
    logic [ADDR_W-1:0]       parent;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign left      = {pos_reg, 1'b1};
    assign right_ext = {1'b0, left} + 1'b1;
    assign parent    = (pos_reg - 1'b1) >> 1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        pidx_next  = pidx_reg;
        cur_next   = cur_reg;
        pv_next    = pv_reg;
        min_next   = min_reg;
        mem_req    = '0;
        cmp_req.a  = cur_reg;
        cmp_req.b  = rd_data;
        load_out   = 1'b0;
        ld_status  = ST_DONE;
        ld_min     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            load_out  = 1'b1;
                            ld_status = ST_FULL;
                        end
                        else
                        begin
                            cur_next   = value;
                            pos_next   = count_reg[ADDR_W-1:0];
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            load_out  = 1'b1;
                            ld_status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = '0;
                            count_next    = count_reg - 1'b1;
                            state_next    = S_EX1;
                        end
                    end
                end
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = cur_reg;
                    count_next    = count_reg + 1'b1;
                    load_out      = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = parent;
                    state_next    = S_UPC;
                end
            end
            S_UPC:
            begin
                cmp_req.a = cur_reg;
                cmp_req.b = rd_data;
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (cmp_lt)
                begin
                    mem_req.wdata = rd_data;
                    pos_next      = parent;
                    state_next    = S_UP;
                end
                else
                begin
                    mem_req.wdata = cur_reg;
                    count_next    = count_reg + 1'b1;
                    load_out      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EX1:
            begin
                min_next = rd_data;
                if (count_reg == '0)
                begin
                    load_out   = 1'b1;
                    ld_min     = rd_data;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = count_reg[ADDR_W-1:0];
                    state_next    = S_EX2;
                end
            end
            S_EX2:
            begin
                cur_next   = rd_data;
                pos_next   = '0;
                state_next = S_DN;
            end
            S_DN:
            begin
                if (left >= count_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = cur_reg;
                    load_out      = 1'b1;
                    ld_min        = min_reg;
                    state_next    = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = left[ADDR_W-1:0];
                    state_next    = S_DNL;
                end
            end
            S_DNL:
            begin
                pv_next   = rd_data;
                pidx_next = left[ADDR_W-1:0];
                if (right_ext < {1'b0, count_reg})
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = left[ADDR_W-1:0] + 1'b1;
                    state_next    = S_DNR;
                end
                else
                begin
                    state_next = S_DNC;
                end
            end
            S_DNR:
            begin
                // right child wins only when strictly smaller
                cmp_req.a = rd_data;
                cmp_req.b = pv_reg;
                if (cmp_lt)
                begin
                    pv_next   = rd_data;
                    pidx_next = pidx_reg + 1'b1;
                end
                state_next = S_DNC;
            end
            S_DNC:
            begin
                cmp_req.a = pv_reg;
                cmp_req.b = cur_reg;
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (cmp_lt)
                begin
                    mem_req.wdata = pv_reg;
                    pos_next      = pidx_reg;
                    state_next    = S_DN;
                end
                else
                begin
                    mem_req.wdata = cur_reg;
                    load_out      = 1'b1;
                    ld_min        = min_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_min_next    = out_min_reg;
        out_count_next  = out_count_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ld_status;
            out_min_next    = ld_min;
            out_count_next  = ENTRY_W'(count_next);
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        pidx_reg       <= pidx_next;
        cur_reg        <= cur_next;
        pv_reg         <= pv_next;
        min_reg        <= min_next;
        out_status_reg <= out_status_next;
        out_min_reg    <= out_min_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign min_value   = out_min_reg;
    assign entry_count = out_count_reg;

endmodule

// ===== hw/rtl/binary_min_heap_queue.sv =====
// ---------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of signed 32-bit values held as a binary min-heap in RAM.
// ---------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_valid/in_stall   op, value
//  out      out_valid/out_stall status, min_value, entry_count
//
//  Insert: per level climbed, reads the parent and moves it down while larger;
//  a stop writes the value at the hole. Refusals load at the accept edge.
//  Extract: reads root and last entry, then per level reads the children,
//  moves the smaller up while below the value; returns at once if it empties.
//  One RAM read port and one shared comparator serve both; one beat in flight.
//  Reset empties the heap without clearing RAM; in_stall holds while busy.
// ---------------------------------------------------------------------------
module binary_min_heap_queue import bmhq_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0] min_value,
    output logic [ENTRY_W-1:0]      entry_count
);

    mem_req_t                mem_req;
    cmp_req_t                cmp_req;
    logic                    cmp_lt;
    logic [VAL_W-1:0]        rd_raw;
    logic signed [VAL_W-1:0] rd_data;

    assign rd_data = rd_raw;

    bmhq_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .min_value   (min_value),
        .entry_count (entry_count),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .cmp_req     (cmp_req),
        .cmp_lt      (cmp_lt)
    );

    bmhq_cmp u_cmp (
        .req (cmp_req),
        .lt  (cmp_lt)
    );

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_raw)
    );

endmodule

// ===== hw/rtl/bmhq_chk.sv =====
// ---------------------------------------------------------------------------
// bmhq_chk
// Port-level checks on the heap queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bmhq_chk import bmhq_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [STAT_W-1:0]       status,
    input logic signed [VAL_W-1:0] min_value,
    input logic [ENTRY_W-1:0]      entry_count
);

    logic                              in_beat;
    logic                              out_wait;
    logic                              empty_beat;
    logic                              full_beat;
    logic                              empty_ok;
    logic                              full_ok;
    logic [STAT_W+VAL_W+ENTRY_W-1:0]   out_bus;

    assign in_beat    = in_valid && !in_stall;
    assign out_wait   = out_valid && out_stall;
    assign empty_beat = out_valid && (status == ST_EMPTY);
    assign full_beat  = out_valid && (status == ST_FULL);
    assign empty_ok   = (min_value == '0) && (entry_count == '0);
    assign full_ok    = (min_value == '0) && (entry_count == ENTRY_W'(CAPACITY));
    assign out_bus    = {status, min_value, entry_count};

    `CHK_RUN(a_empty_result, empty_beat |-> empty_ok, "empty result with nonzero fields")
    `CHK_RUN(a_full_result, full_beat |-> full_ok, "full result with wrong fields")
    `CHK_RUN(a_out_hold, out_wait |=> out_valid && $stable(out_bus), "stalled beat changed")
    `CHK_RUN(a_one_in_flight, in_beat && out_wait |-> 1'b0, "input taken while result stalled")
    `CHK_ALL(a_reset_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind binary_min_heap_queue bmhq_chk u_bmhq_chk (.*);
